// File: rtl/core/olb_pkg.sv
package olb_pkg;

  localparam int OP_W       = 2;
  localparam int POS_W      = 5;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int DATA_OUT_W = 32;
  localparam int OUT_IDX_W  = 4;
  localparam int OUT_CNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH
  } state_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic del;
    logic upd;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: rtl/core/olb_if.sv
interface olb_req_if;
  import olb_pkg::*;

  logic                      valid;
  logic                      ready;
  op_t                       op;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink (input valid, input op, input position, input value, output ready);
endinterface

interface olb_rsp_if;
  import olb_pkg::*;

  logic                         valid;
  logic                         ready;
  status_t                      status;
  logic signed [DATA_OUT_W-1:0] data;
  logic [OUT_IDX_W-1:0]         found_index;
  logic [OUT_CNT_W-1:0]         entry_count_out;

  modport source (output valid, output status, output data, output found_index,
                  output entry_count_out, input ready);
  modport sink (input valid, input status, input data, input found_index,
                input entry_count_out, output ready);
endinterface

// File: rtl/core/olb_cell.sv
module olb_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32,
  parameter int PW         = 5,
  parameter int CNTW       = 5
) (
  input  logic                   clk,
  input  olb_pkg::cell_ctrl_t    ctrl,
  input  logic [PW-1:0]          pos,
  input  logic [CNTW-1:0]        cnt,
  input  logic [DATA_WIDTH-1:0]  key,
  input  logic [DATA_WIDTH-1:0]  left_val,
  input  logic [DATA_WIDTH-1:0]  right_val,
  input  logic                   right_flag,
  output logic [DATA_WIDTH-1:0]  val,
  output logic                   flag,
  output logic [DATA_WIDTH-1:0]  sel_val
);

  // 1-based list position held by this cell
  localparam logic [PW-1:0] MY = PW'(IDX + 1);

  always_ff @(posedge clk) begin
    if (ctrl.ins && (MY > pos)) begin
      val <= left_val;
    end else if ((ctrl.ins || ctrl.upd) && (MY == pos)) begin
      val <= key;
    end else if (ctrl.del && (MY >= pos)) begin
      val <= right_val;
    end
  end

  // match flags load in parallel, then drain toward cell 0 one step a cycle
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      flag <= (val == key) && (MY <= PW'(cnt));
    end else if (ctrl.shift) begin
      flag <= right_flag;
    end
  end

  assign sel_val = (MY == pos) ? val : '0;

endmodule

// File: rtl/core/ordered_list_buffer.sv
// Ordered list of up to DEPTH values held in a row of cells, one entry per cell.
// Insert, delete and update act on every cell at once; a new item is taken
// every cycle as long as the result register is emptied and no search is running.
// Search first loads a match flag in every cell, then shifts the flags one cell
// per cycle toward the head of the row; the request side is held until a hit
// reaches cell 0 or the scan reaches the entry count, and the output register is free.
// Results leave through a single output register; stored values are DATA_WIDTH
// bits wide, the key is zero-extended or truncated to that width and returned
// data is zero-extended or truncated to 32 bits.
module ordered_list_buffer #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  olb_req_if.sink    req,
  olb_rsp_if.source  rsp
);
  import olb_pkg::*;

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int PW   = (CNTW > POS_W) ? CNTW : POS_W;

  state_t                  state, state_next;
  logic [CNTW-1:0]         count, count_next;
  logic [CNTW-1:0]         idx, idx_next;
  logic [DATA_WIDTH-1:0]   key_reg, key_next;
  cell_ctrl_t              ctrl;

  logic                    out_valid;
  status_t                 out_status;
  logic [DATA_OUT_W-1:0]   out_data;
  logic [OUT_IDX_W-1:0]    out_index;
  logic [OUT_CNT_W-1:0]    out_count;

  logic                    res_load;
  status_t                 res_status;
  logic [DATA_OUT_W-1:0]   res_data;
  logic [OUT_IDX_W-1:0]    res_index;

  logic                    out_free;
  logic                    in_fire;
  logic                    scan_done;
  logic [PW-1:0]           pos_w;
  logic [PW-1:0]           cnt_w;
  logic [DATA_WIDTH-1:0]   key_in;
  logic                    ins_pos_ok;
  logic                    pos_ok;
  logic                    full;
  logic [DATA_WIDTH-1:0]   sel_or;

  logic [DATA_WIDTH-1:0]   elem       [DEPTH];
  logic                    flag       [DEPTH];
  logic [DATA_WIDTH-1:0]   sel_val    [DEPTH];
  logic [DATA_WIDTH-1:0]   left_val   [DEPTH];
  logic [DATA_WIDTH-1:0]   right_val  [DEPTH];
  logic                    right_flag [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_val[g] = '0;
    end else begin : g_body
      assign left_val[g] = elem[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_val[g]  = elem[g];
      assign right_flag[g] = 1'b0;
    end else begin : g_inner
      assign right_val[g]  = elem[g+1];
      assign right_flag[g] = flag[g+1];
    end

    olb_cell #(
      .IDX        (g),
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW),
      .CNTW       (CNTW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos_w),
      .cnt        (count),
      .key        (key_in),
      .left_val   (left_val[g]),
      .right_val  (right_val[g]),
      .right_flag (right_flag[g]),
      .val        (elem[g]),
      .flag       (flag[g]),
      .sel_val    (sel_val[g])
    );
  end

  // at most one cell drives a nonzero selected value
  always_comb begin
    sel_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_or = sel_or | sel_val[i];
    end
  end

  assign out_free   = !out_valid || rsp.ready;
  assign in_fire    = req.valid && req.ready;
  assign scan_done  = flag[0] || (idx == count);
  assign pos_w      = PW'(req.position);
  assign cnt_w      = PW'(count);
  assign key_in     = DATA_WIDTH'($unsigned(req.value));
  assign ins_pos_ok = (pos_w != '0) && ((pos_w - PW'(1)) <= cnt_w);
  assign pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
  assign full       = (count == CNTW'(DEPTH));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && (req.op == OP_SEARCH)) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (scan_done && out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    count_next = count;
    idx_next   = idx;
    key_next   = key_reg;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_data   = '0;
    res_index  = '0;
    req.ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = out_free && !rst;
        if (in_fire) begin
          unique case (req.op)
            OP_INSERT: begin
              res_load = 1'b1;
              priority if (!ins_pos_ok) begin
                res_status = ST_BAD_POS;
              end else if (full) begin
                res_status = ST_FULL;
              end else begin
                ctrl.ins   = 1'b1;
                count_next = count + CNTW'(1);
              end
            end
            OP_DELETE: begin
              res_load = 1'b1;
              if (!pos_ok) begin
                res_status = ST_BAD_POS;
              end else begin
                ctrl.del   = 1'b1;
                count_next = count - CNTW'(1);
                res_data   = DATA_OUT_W'(sel_or);
              end
            end
            OP_UPDATE: begin
              res_load = 1'b1;
              if (!pos_ok) begin
                res_status = ST_BAD_POS;
              end else begin
                ctrl.upd = 1'b1;
              end
            end
            OP_SEARCH: begin
              ctrl.load = 1'b1;
              idx_next  = '0;
              key_next  = key_in;
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (scan_done) begin
          if (out_free) begin
            res_load = 1'b1;
            if (flag[0]) begin
              res_data  = DATA_OUT_W'(key_reg);
              res_index = OUT_IDX_W'(idx);
            end else begin
              res_status = ST_NOT_FOUND;
            end
          end
        end else begin
          ctrl.shift = 1'b1;
          idx_next   = idx + CNTW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    key_reg <= key_next;
    if (res_load) begin
      out_status <= res_status;
      out_data   <= res_data;
      out_index  <= res_index;
      out_count  <= OUT_CNT_W'(count_next);
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.data            = out_data;
  assign rsp.found_index     = out_index;
  assign rsp.entry_count_out = out_count;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("entry count above depth");

  a_ctrl_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctrl))
    else $error("more than one cell command at once");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (idx <= count))
    else $error("search scan ran past the list");

  a_count_source: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |-> $past(in_fire))
    else $error("entry count changed without an accepted item");
`endif

endmodule
